// ===== hw/rtl/pci_mst_pkg.sv =====
// types and constants shared by the pci single transfer master
package pci_mst_pkg;

  typedef enum logic [2:0] {
    PH_IDLE   = 3'd0,
    PH_REQ    = 3'd1,
    PH_DAC    = 3'd2,
    PH_CMD    = 3'd3,
    PH_DEVSEL = 3'd4,
    PH_DATA   = 3'd5
  } phase_t;

  localparam logic [2:0] ST_NONE    = 3'd0;
  localparam logic [2:0] ST_DONE    = 3'd1;
  localparam logic [2:0] ST_ABORT   = 3'd2;
  localparam logic [2:0] ST_RETRY   = 3'd3;
  localparam logic [2:0] ST_TIMEOUT = 3'd4;

  localparam logic [7:0] CFG_GRANT_LIMIT = 8'd0;
  localparam logic [7:0] CFG_READY_LIMIT = 8'd1;

  localparam logic [3:0]  CMD_DAC         = 4'hD;
  localparam logic [31:0] ALL_ONES        = 32'hFFFF_FFFF;
  localparam logic [8:0]  DEVSEL_EXTRA    = 9'd3;
  localparam logic [7:0]  GRANT_LIMIT_RST = 8'd32;
  localparam logic [8:0]  READY_LIMIT_RST = 9'd256;

  typedef struct packed {
    logic        start_valid;
    logic        is_write;
    logic [63:0] address;
    logic [3:0]  bus_command;
    logic [3:0]  byte_enable_n;
    logic [31:0] write_data;
    logic        gnt_n;
    logic        devsel_n;
    logic        trdy_n;
    logic        stop_n;
    logic [31:0] ad_in;
  } in_item_t;

  typedef struct packed {
    logic        req_n;
    logic        frame_n;
    logic        irdy_n;
    logic        control_drive;
    logic [31:0] ad_out;
    logic        ad_drive;
    logic [3:0]  cbe_out;
    logic        cbe_drive;
    logic        parity_out;
    logic        parity_drive;
    logic [2:0]  result_status;
    logic [31:0] read_data;
  } out_item_t;

endpackage

// ===== hw/rtl/pci_master_single_transfer.sv =====
// pci bus master running one 32-bit read or write per request
//
// channel  direction  handshake               word
// in_      input      in_valid / in_ready     pci_mst_pkg::in_item_t, one bus clock
// out_     output     out_valid / out_ready   pci_mst_pkg::out_item_t, drive values
// cfg_     input      cfg_valid / cfg_ready   register index and write data
//
// one result word per input word, registered: a result word is valid in the cycle after
// its input word is accepted; one word per cycle sustained while out_ready stays high
// in_ready stays high while the output register is empty or being emptied
// rst_n is synchronous; it clears phase, latches and the output valid and reloads the reset limits
// cfg_ready is always high; limits take effect on the next accepted word
module pci_master_single_transfer (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  pci_mst_pkg::in_item_t in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output pci_mst_pkg::out_item_t out_data,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [7:0]            cfg_index,
  input  logic [8:0]            cfg_data
);

  pci_mst_pkg::phase_t phase_r, phase_nxt;
  logic [63:0] addr_r, addr_nxt;
  logic [3:0]  cmd_r, cmd_nxt;
  logic [3:0]  be_r, be_nxt;
  logic [31:0] wdata_r, wdata_nxt;
  logic        write_r, write_nxt;
  logic [8:0]  wait_r, wait_nxt;
  logic        par_r, par_nxt;
  logic        par_vld_r, par_vld_nxt;
  logic [7:0]  glimit_r;
  logic [8:0]  rlimit_r;
  logic        out_vld_r;
  pci_mst_pkg::out_item_t out_r, res_c;

  logic        in_fire;
  logic [8:0]  glimit_eff, rlimit_eff;
  logic [8:0]  dc_cnt;
  logic [31:0] fail_data;

  assign in_ready  = !out_vld_r || out_ready;
  assign in_fire   = in_valid && in_ready;
  assign cfg_ready = 1'b1;
  assign out_valid = out_vld_r;
  assign out_data  = out_r;

  // a zero limit behaves as one
  assign glimit_eff = (glimit_r == 8'd0) ? 9'd1 : {1'b0, glimit_r};
  assign rlimit_eff = (rlimit_r == 9'd0) ? 9'd1 : rlimit_r;
  assign fail_data  = write_r ? 32'd0 : pci_mst_pkg::ALL_ONES;

  always_comb begin
    phase_nxt = phase_r;
    addr_nxt  = addr_r;
    cmd_nxt   = cmd_r;
    be_nxt    = be_r;
    wdata_nxt = wdata_r;
    write_nxt = write_r;
    wait_nxt  = wait_r;
    res_c     = '0;
    res_c.req_n   = 1'b1;
    res_c.frame_n = 1'b1;
    res_c.irdy_n  = 1'b1;
    res_c.parity_out   = par_r;
    res_c.parity_drive = par_vld_r;
    // data phase count starts from zero on the edge devsel is found
    dc_cnt = ((phase_r == pci_mst_pkg::PH_DEVSEL) ? 9'd0 : wait_r) + 9'd1;

    unique case (phase_r)
      pci_mst_pkg::PH_IDLE: begin
        if (in_data.start_valid) begin
          write_nxt = in_data.is_write;
          addr_nxt  = in_data.address;
          cmd_nxt   = in_data.bus_command;
          be_nxt    = in_data.byte_enable_n;
          wdata_nxt = in_data.write_data;
          wait_nxt  = 9'd0;
          if (in_data.gnt_n) begin
            phase_nxt = pci_mst_pkg::PH_REQ;
          end else if (in_data.address[63:32] != 32'd0) begin
            phase_nxt = pci_mst_pkg::PH_DAC;
          end else begin
            phase_nxt = pci_mst_pkg::PH_CMD;
          end
        end
      end
      pci_mst_pkg::PH_REQ: begin
        if (!in_data.gnt_n) begin
          phase_nxt = (addr_r[63:32] != 32'd0) ? pci_mst_pkg::PH_DAC
                                               : pci_mst_pkg::PH_CMD;
        end else begin
          wait_nxt = wait_r + 9'd1;
          if (wait_nxt >= glimit_eff) begin
            res_c.result_status = pci_mst_pkg::ST_TIMEOUT;
            res_c.read_data     = fail_data;
            phase_nxt           = pci_mst_pkg::PH_IDLE;
          end
        end
      end
      pci_mst_pkg::PH_DAC: begin
        phase_nxt = pci_mst_pkg::PH_CMD;
      end
      pci_mst_pkg::PH_CMD: begin
        phase_nxt = pci_mst_pkg::PH_DEVSEL;
        wait_nxt  = 9'd0;
      end
      pci_mst_pkg::PH_DEVSEL, pci_mst_pkg::PH_DATA: begin
        if (phase_r == pci_mst_pkg::PH_DEVSEL && in_data.devsel_n) begin
          if (wait_r >= pci_mst_pkg::DEVSEL_EXTRA) begin
            res_c.result_status = pci_mst_pkg::ST_ABORT;
            res_c.read_data     = fail_data;
            phase_nxt           = pci_mst_pkg::PH_IDLE;
          end else begin
            wait_nxt = wait_r + 9'd1;
          end
        end else if (!in_data.trdy_n) begin
          res_c.result_status = pci_mst_pkg::ST_DONE;
          res_c.read_data     = write_r ? 32'd0 : in_data.ad_in;
          phase_nxt           = pci_mst_pkg::PH_IDLE;
          wait_nxt            = 9'd0;
        end else if (!write_r && !in_data.stop_n) begin
          res_c.result_status = pci_mst_pkg::ST_RETRY;
          res_c.read_data     = pci_mst_pkg::ALL_ONES;
          phase_nxt           = pci_mst_pkg::PH_IDLE;
          wait_nxt            = 9'd0;
        end else begin
          wait_nxt = dc_cnt;
          if (dc_cnt >= rlimit_eff) begin
            res_c.result_status = pci_mst_pkg::ST_TIMEOUT;
            res_c.read_data     = fail_data;
            phase_nxt           = pci_mst_pkg::PH_IDLE;
          end else begin
            phase_nxt = pci_mst_pkg::PH_DATA;
          end
        end
      end
      default: begin
        phase_nxt = pci_mst_pkg::PH_IDLE;
      end
    endcase

    // bus drive follows the phase entered on this edge
    unique case (phase_nxt)
      pci_mst_pkg::PH_REQ: begin
        res_c.req_n = 1'b0;
      end
      pci_mst_pkg::PH_DAC: begin
        res_c.frame_n       = 1'b0;
        res_c.control_drive = 1'b1;
        res_c.ad_out        = addr_nxt[31:0];
        res_c.ad_drive      = 1'b1;
        res_c.cbe_out       = pci_mst_pkg::CMD_DAC;
        res_c.cbe_drive     = 1'b1;
      end
      pci_mst_pkg::PH_CMD: begin
        res_c.frame_n       = 1'b0;
        res_c.control_drive = 1'b1;
        res_c.ad_out        = (addr_nxt[63:32] != 32'd0) ? addr_nxt[63:32] : addr_nxt[31:0];
        res_c.ad_drive      = 1'b1;
        res_c.cbe_out       = cmd_nxt;
        res_c.cbe_drive     = 1'b1;
      end
      pci_mst_pkg::PH_DEVSEL, pci_mst_pkg::PH_DATA: begin
        res_c.irdy_n        = 1'b0;
        res_c.control_drive = 1'b1;
        res_c.cbe_out       = be_nxt;
        res_c.cbe_drive     = 1'b1;
        res_c.ad_out        = write_nxt ? wdata_nxt : 32'd0;
        res_c.ad_drive      = write_nxt;
      end
      default: begin
      end
    endcase

    par_vld_nxt = res_c.ad_drive;
    par_nxt     = res_c.ad_drive && ((^res_c.ad_out) ^ (^res_c.cbe_out));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= pci_mst_pkg::PH_IDLE;
      addr_r    <= '0;
      cmd_r     <= '0;
      be_r      <= 4'hF;
      wdata_r   <= '0;
      write_r   <= 1'b0;
      wait_r    <= '0;
      par_r     <= 1'b0;
      par_vld_r <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      if (in_fire) begin
        phase_r   <= phase_nxt;
        addr_r    <= addr_nxt;
        cmd_r     <= cmd_nxt;
        be_r      <= be_nxt;
        wdata_r   <= wdata_nxt;
        write_r   <= write_nxt;
        wait_r    <= wait_nxt;
        par_r     <= par_nxt;
        par_vld_r <= par_vld_nxt;
        out_vld_r <= 1'b1;
      end else if (out_ready) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      out_r <= res_c;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      glimit_r <= pci_mst_pkg::GRANT_LIMIT_RST;
      rlimit_r <= pci_mst_pkg::READY_LIMIT_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        pci_mst_pkg::CFG_GRANT_LIMIT: glimit_r <= cfg_data[7:0];
        pci_mst_pkg::CFG_READY_LIMIT: rlimit_r <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // a word that ends a transfer releases the request, control, ad and cbe drivers
  a_release_on_end: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r && out_r.result_status != pci_mst_pkg::ST_NONE
    |-> out_r.req_n && !out_r.control_drive && !out_r.ad_drive && !out_r.cbe_drive)
    else $error("drivers still on in the ending word");

  a_idle_after_end: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && res_c.result_status != pci_mst_pkg::ST_NONE
    |=> phase_r == pci_mst_pkg::PH_IDLE)
    else $error("not idle after a transfer ended");

  a_dac_then_cmd: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == pci_mst_pkg::PH_DAC
    |=> phase_r == pci_mst_pkg::PH_DAC || phase_r == pci_mst_pkg::PH_CMD)
    else $error("dual address cycle not followed by command phase");

  a_parity_drive_matches: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> par_vld_r == out_r.ad_drive)
    else $error("parity enable out of step with ad drive");

endmodule
